[rtl/lpmm_pkg.sv]
package lpmm_pkg;

    // Default store depth; the top level hands its own value down.
    localparam int DEF_MAX_ITEMS = 64;

    // Fixed field widths.
    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 38;
    localparam int PC_W     = 7;

    // One loaded item.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                last_item;
    } item_t;

    // One emitted result.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_out;
        logic                break_after;
        logic [SUM_W-1:0]    part_limit;
        logic                error;
        logic                last_result;
    } result_t;

    // Summary of one loaded sequence, handed from the front to the back.
    typedef struct packed {
        logic                error;
        logic [PC_W-1:0]     parts_count;
        logic [SUM_W-1:0]    total;
        logic [WEIGHT_W-1:0] largest;
    } job_t;

    // Sequencer states of the back end.
    typedef enum logic [3:0] {
        B_IDLE,
        B_ERROR,
        B_MID,
        B_SCAN,
        B_DECIDE,
        B_MARK,
        B_EMIT_START,
        B_EMIT,
        B_DONE
    } back_state_t;

endpackage

[rtl/lpmm_item_ram.sv]
module lpmm_item_ram #(
    parameter int ADDR_W = $clog2(lpmm_pkg::DEF_MAX_ITEMS) + 1
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [lpmm_pkg::WEIGHT_W-1:0] wdata,
    input  logic                          re,
    input  logic [ADDR_W-1:0]             raddr,
    output logic [lpmm_pkg::WEIGHT_W-1:0] rdata
);
    import lpmm_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic [WEIGHT_W-1:0] mem [DEPTH];
    logic [WEIGHT_W-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lpmm_job_fifo.sv]
module lpmm_job_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head,
    output logic              full,
    output logic              empty
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A job is never pushed into a full queue nor popped from an empty one.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("job queue read while empty");

endmodule

[rtl/lpmm_front.sv]
module lpmm_front #(
    parameter int MAX_ITEMS = lpmm_pkg::DEF_MAX_ITEMS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lpmm_pkg::item_t                     item,
    input  logic                                cfg_we,
    input  logic [lpmm_pkg::PC_W-1:0]           cfg_wdata,
    input  logic                                queue_full,
    output logic                                push,
    output lpmm_pkg::job_t                      job,
    output logic [$clog2(MAX_ITEMS+1)-1:0]      job_count,
    output logic                                ram_we,
    output logic [$clog2(MAX_ITEMS):0]          ram_waddr,
    output logic [lpmm_pkg::WEIGHT_W-1:0]       ram_wdata
);
    import lpmm_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CMP_W = (CNT_W > PC_W) ? CNT_W : PC_W;

    logic [PC_W-1:0]     pc_reg;
    logic [CNT_W-1:0]    count_reg, count_next, upd_count;
    logic [SUM_W-1:0]    sum_reg, sum_next, upd_sum;
    logic                over_reg, over_next, upd_over;
    logic [WEIGHT_W-1:0] largest_reg, largest_next, upd_largest;
    logic                bank_reg, bank_next;
    logic [SUM_W:0]      sum_wide;
    logic                accept;
    logic                has_room;

    // The front stalls only when both store banks hold pending sequences.
    assign busy     = queue_full;
    assign accept   = start && !busy;
    assign has_room = (count_reg < CNT_W'(MAX_ITEMS));

    // Running statistics including the item on the input.
    always_comb
    begin
        sum_wide    = {1'b0, sum_reg} + (SUM_W + 1)'(item.weight);
        upd_count   = count_reg;
        upd_sum     = sum_reg;
        upd_over    = over_reg;
        upd_largest = largest_reg;
        if (has_room)
        begin
            upd_count = count_reg + CNT_W'(1);
            upd_sum   = sum_wide[SUM_W-1:0];
            upd_over  = over_reg | sum_wide[SUM_W];
            if (item.weight > largest_reg)
            begin
                upd_largest = item.weight;
            end
        end
    end

    // Register updates; the final item closes the sequence and swaps banks.
    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        over_next    = over_reg;
        largest_next = largest_reg;
        bank_next    = bank_reg;
        if (accept)
        begin
            if (item.last_item)
            begin
                count_next   = '0;
                sum_next     = '0;
                over_next    = 1'b0;
                largest_next = '0;
                bank_next    = ~bank_reg;
            end
            else
            begin
                count_next   = upd_count;
                sum_next     = upd_sum;
                over_next    = upd_over;
                largest_next = upd_largest;
            end
        end
    end

    // Job summary pushed with the final item.
    always_comb
    begin
        job.error       = (pc_reg == '0) || (CMP_W'(pc_reg) > CMP_W'(upd_count)) || upd_over;
        job.parts_count = pc_reg;
        job.total       = upd_sum;
        job.largest     = upd_largest;
    end

    assign job_count = upd_count;
    assign push      = accept && item.last_item;
    assign ram_we    = accept && has_room;
    assign ram_waddr = {bank_reg, count_reg[IDX_W-1:0]};
    assign ram_wdata = item.weight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= PC_W'(1);
            count_reg   <= '0;
            sum_reg     <= '0;
            over_reg    <= 1'b0;
            largest_reg <= '0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            over_reg    <= over_next;
            largest_reg <= largest_next;
            bank_reg    <= bank_next;
        end
    end

endmodule

[rtl/lpmm_back.sv]
module lpmm_back #(
    parameter int MAX_ITEMS = lpmm_pkg::DEF_MAX_ITEMS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    input  lpmm_pkg::job_t                      job,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]      job_count,
    output logic                                pop,
    output logic                                ram_re,
    output logic [$clog2(MAX_ITEMS):0]          ram_raddr,
    input  logic [lpmm_pkg::WEIGHT_W-1:0]       ram_rdata,
    output logic                                result_valid,
    output lpmm_pkg::result_t                   result
);
    import lpmm_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CMP_W = (CNT_W > PC_W) ? CNT_W : PC_W;

    back_state_t      state_reg, state_next;
    logic [SUM_W-1:0] low_reg, high_reg, best_reg, mid_reg, run_reg;
    logic [CNT_W-1:0] parts_reg;
    logic [IDX_W-1:0] iss_idx_reg, rd_idx_reg;
    logic             issuing_reg, rd_valid_reg, bank_reg;
    logic [PC_W-1:0]  need_reg;
    logic             flag_mem [MAX_ITEMS];
    logic             flag_rd_reg;
    result_t          result_reg;
    logic             result_valid_reg;

    logic             load_search, start_scan, start_emit, emit_error;
    logic             scan_phase, emit_phase, mark_phase;
    logic             scan_end, emit_end, fits, low_le_high, over_lim, fin, add_brk;
    logic             iss_last;
    logic [SUM_W:0]   mid_sum, run_sum;
    logic [SUM_W-1:0] limit;
    logic [CNT_W-1:0] count_m1;
    logic [IDX_W-1:0] last_idx;

    // Shared datapath terms.
    assign count_m1    = job_count - CNT_W'(1);
    assign last_idx    = count_m1[IDX_W-1:0];
    assign mid_sum     = {1'b0, low_reg} + {1'b0, high_reg};
    assign low_le_high = (low_reg <= high_reg);
    assign fits        = (CMP_W'(parts_reg) <= CMP_W'(job.parts_count));
    assign limit       = (state_reg == B_MARK) ? best_reg : mid_reg;
    assign run_sum     = {1'b0, run_reg} + (SUM_W + 1)'(ram_rdata);
    assign over_lim    = (run_sum > {1'b0, limit});
    assign fin         = (rd_idx_reg == last_idx);
    assign add_brk     = !flag_rd_reg && (need_reg != '0) && !fin;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.error ? B_ERROR : B_MID;
                end
            end
            B_ERROR:      state_next = B_DONE;
            B_MID:        state_next = low_le_high ? B_SCAN : B_MARK;
            B_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = B_DECIDE;
                end
            end
            B_DECIDE:     state_next = (fits && (mid_reg == '0)) ? B_MARK : B_MID;
            B_MARK:
            begin
                if (scan_end)
                begin
                    state_next = B_EMIT_START;
                end
            end
            B_EMIT_START: state_next = B_EMIT;
            B_EMIT:
            begin
                if (emit_end)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:       state_next = B_IDLE;
            default:      state_next = B_IDLE;
        endcase
    end

    // Control decoded from the state.
    always_comb
    begin
        scan_phase  = (state_reg == B_SCAN) || (state_reg == B_MARK);
        mark_phase  = (state_reg == B_MARK);
        emit_phase  = (state_reg == B_EMIT);
        load_search = (state_reg == B_IDLE) && job_valid && !job.error;
        start_scan  = (state_reg == B_MID)
                      || ((state_reg == B_DECIDE) && fits && (mid_reg == '0));
        start_emit  = (state_reg == B_EMIT_START);
        emit_error  = (state_reg == B_ERROR);
        pop         = (state_reg == B_DONE);
        scan_end    = scan_phase && rd_valid_reg && (rd_idx_reg == '0);
        emit_end    = emit_phase && rd_valid_reg && fin;
        iss_last    = emit_phase ? (iss_idx_reg == last_idx) : (iss_idx_reg == '0);
    end

    assign ram_re    = issuing_reg;
    assign ram_raddr = {bank_reg, iss_idx_reg};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            issuing_reg      <= 1'b0;
            rd_valid_reg     <= 1'b0;
            bank_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start_scan || start_emit)
            begin
                issuing_reg <= 1'b1;
            end
            else if (issuing_reg && iss_last)
            begin
                issuing_reg <= 1'b0;
            end
            rd_valid_reg <= issuing_reg;
            if (pop)
            begin
                bank_reg <= ~bank_reg;
            end
            result_valid_reg <= emit_error || (emit_phase && rd_valid_reg);
        end
    end

    // Search, scan and emit datapath.
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= iss_idx_reg;
        if (start_scan)
        begin
            iss_idx_reg <= last_idx;
        end
        else if (start_emit)
        begin
            iss_idx_reg <= '0;
        end
        else if (issuing_reg)
        begin
            iss_idx_reg <= emit_phase ? (iss_idx_reg + IDX_W'(1)) : (iss_idx_reg - IDX_W'(1));
        end

        if (load_search)
        begin
            low_reg  <= SUM_W'(job.largest);
            high_reg <= job.total;
            best_reg <= job.total;
        end
        if (state_reg == B_MID)
        begin
            mid_reg <= mid_sum[SUM_W:1];
        end
        if (state_reg == B_DECIDE)
        begin
            if (fits)
            begin
                best_reg <= mid_reg;
                high_reg <= mid_reg - SUM_W'(1);
            end
            else
            begin
                low_reg <= mid_reg + SUM_W'(1);
            end
        end

        // Greedy split from the right end.
        if (start_scan)
        begin
            run_reg   <= '0;
            parts_reg <= CNT_W'(1);
        end
        else if (scan_phase && rd_valid_reg)
        begin
            if (over_lim)
            begin
                parts_reg <= parts_reg + CNT_W'(1);
                run_reg   <= SUM_W'(ram_rdata);
            end
            else
            begin
                run_reg <= run_sum[SUM_W-1:0];
            end
        end
        if (mark_phase && rd_valid_reg)
        begin
            flag_mem[rd_idx_reg] <= over_lim;
        end

        // Emission with extra breaks placed after the leftmost free items.
        if (start_emit)
        begin
            need_reg <= job.parts_count - PC_W'(parts_reg);
        end
        else if (emit_phase && rd_valid_reg && add_brk)
        begin
            need_reg <= need_reg - PC_W'(1);
        end
        if (emit_phase && issuing_reg)
        begin
            flag_rd_reg <= flag_mem[iss_idx_reg];
        end
        if (emit_error)
        begin
            result_reg.weight_out  <= '0;
            result_reg.break_after <= 1'b0;
            result_reg.part_limit  <= '0;
            result_reg.error       <= 1'b1;
            result_reg.last_result <= 1'b1;
        end
        else if (emit_phase && rd_valid_reg)
        begin
            result_reg.weight_out  <= ram_rdata;
            result_reg.break_after <= !fin && (flag_rd_reg || add_brk);
            result_reg.part_limit  <= best_reg;
            result_reg.error       <= 1'b0;
            result_reg.last_result <= fin;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Read data only returns while a scan or the emission is running.
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == B_SCAN || state_reg == B_MARK || state_reg == B_EMIT))
        else $error("read data returned outside a scan");
    // All extra breaks are placed before the final item goes out.
    a_need_spent: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_phase && rd_valid_reg && fin) |-> (need_reg == '0))
        else $error("extra breaks left over at the end of a run");
    // The final result of a run is shown while the job is retired.
    a_last_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.last_result) |-> (state_reg == B_DONE))
        else $error("final result not aligned with job retirement");

endmodule

[rtl/linear_partition_min_max.sv]
// Linear partition of a weight sequence into parts_count contiguous parts with the
// smallest possible largest part sum.
// Input: an item transfers on a clock edge with start high and busy low. Weights load
// in order; the item with last_item set closes the sequence. Up to MAX_ITEMS weights
// are stored; later ones are dropped, but last_item still closes the sequence.
// Configuration: user writes parts_count (cfg_we/cfg_wdata) while idle; not enforced.
// Output: one result per stored weight, in order, each valid for one cycle with
// result_valid; the receiver cannot stall. A bad part count or a sum overflow gives a
// single result with error and last_result set.
// Processing: loading stores one item per transfer. A sequence then takes R binary
// search rounds (at most 39, ceil(log2(total - largest + 1)) + 1), each one greedy
// scan streaming the stored items through the single read port of the item store,
// one per cycle; a marking scan at the best limit and the emission pass follow.
// The store has two banks: the next sequence loads while the previous one computes;
// busy rises only when both banks wait.
// Reset: clears counters, sums and the sequencer; parts_count returns to 1.
module linear_partition_min_max #(
    parameter int MAX_ITEMS = lpmm_pkg::DEF_MAX_ITEMS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  lpmm_pkg::item_t           item,
    input  logic                      cfg_we,
    input  logic [lpmm_pkg::PC_W-1:0] cfg_wdata,
    output logic                      result_valid,
    output lpmm_pkg::result_t         result
);
    import lpmm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS) + 1;
    localparam int JOB_W  = $bits(job_t) + CNT_W;

    logic                push, pop, queue_full, queue_empty;
    job_t                push_job, head_job;
    logic [CNT_W-1:0]    push_count, head_count;
    logic [JOB_W-1:0]    head_data;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [WEIGHT_W-1:0] ram_wdata, ram_rdata;

    lpmm_front #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .queue_full(queue_full),
        .push      (push),
        .job       (push_job),
        .job_count (push_count),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    lpmm_item_ram #(
        .ADDR_W(ADDR_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    lpmm_job_fifo #(
        .DATA_W(JOB_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data({push_job, push_count}),
        .pop      (pop),
        .head     (head_data),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    assign head_job   = head_data[JOB_W-1:CNT_W];
    assign head_count = head_data[CNT_W-1:0];

    lpmm_back #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!queue_empty),
        .job         (head_job),
        .job_count   (head_count),
        .pop         (pop),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

[dv/tb_linear_partition_min_max.sv]
module tb_linear_partition_min_max;

    timeunit 1ns;
    timeprecision 1ps;

    import lpmm_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam logic [63:0] SUM_MASK = 64'h3F_FFFF_FFFF;

    // Weight patterns used by the random sequences.
    typedef enum int {
        MIX_FULL,
        MIX_SMALL,
        MIX_EXTREME
    } weight_mix_t;

    // Scoreboard: tracks the loaded sequence and predicts the partition results.
    class partition_scoreboard;
        logic [WEIGHT_W-1:0] seq_weights[STORE_DEPTH];
        int unsigned         seq_len;
        logic [63:0]         seq_total;
        logic [WEIGHT_W-1:0] seq_largest;
        logic [PC_W-1:0]     wanted_parts;
        bit                  bounds[STORE_DEPTH];
        result_t             awaited[$];
        int unsigned         failures;

        function new();
            seq_len = 0;
            seq_total = '0;
            seq_largest = '0;
            wanted_parts = 1;
            failures = 0;
        endfunction

        function void set_parts(logic [PC_W-1:0] value);
            wanted_parts = value;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // Greedy split from the right end; optionally records the boundaries.
        function int unsigned count_parts(logic [63:0] cap, bit record);
            int unsigned parts;
            logic [63:0] acc;
            parts = 1;
            acc = '0;
            if (record)
                foreach (bounds[k])
                    bounds[k] = 1'b0;
            for (int i = int'(seq_len) - 1; i >= 0; i--)
            begin
                if (acc + seq_weights[i] > cap)
                begin
                    parts++;
                    acc = seq_weights[i];
                    if (record)
                        bounds[i] = 1'b1;
                end
                else
                begin
                    acc += seq_weights[i];
                end
            end
            return parts;
        endfunction

        // Binary search for the smallest cap, then the split and its results.
        function void predict_partition();
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] mid;
            logic [63:0] best;
            int unsigned parts;
            int unsigned extra;
            result_t r;
            lo = seq_largest;
            hi = seq_total;
            best = seq_total;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (count_parts(mid, 1'b0) <= wanted_parts)
                begin
                    best = mid;
                    if (mid == 0)
                        break;
                    hi = mid - 1;
                end
                else
                begin
                    lo = mid + 1;
                end
            end
            parts = count_parts(best, 1'b1);
            extra = wanted_parts - parts;
            // Extra boundaries go after the leftmost items that have none yet.
            for (int i = 0; i + 1 < int'(seq_len) && extra > 0; i++)
            begin
                if (!bounds[i])
                begin
                    bounds[i] = 1'b1;
                    extra--;
                end
            end
            for (int i = 0; i < int'(seq_len); i++)
            begin
                r.weight_out  = seq_weights[i];
                r.break_after = (i + 1 == int'(seq_len)) ? 1'b0 : bounds[i];
                r.part_limit  = best[SUM_W-1:0];
                r.error       = 1'b0;
                r.last_result = (i + 1 == int'(seq_len));
                awaited = {awaited, r};
            end
        endfunction

        // Called for every accepted input transfer.
        function void note_item(item_t it);
            result_t r;
            if (seq_len < STORE_DEPTH)
            begin
                seq_weights[seq_len] = it.weight;
                seq_len++;
                seq_total += it.weight;
                if (it.weight > seq_largest)
                    seq_largest = it.weight;
            end
            if (!it.last_item)
                return;
            if (wanted_parts == 0 || wanted_parts > seq_len || seq_total > SUM_MASK)
            begin
                r = '0;
                r.error = 1'b1;
                r.last_result = 1'b1;
                awaited = {awaited, r};
            end
            else
            begin
                predict_partition();
            end
            seq_len = 0;
            seq_total = '0;
            seq_largest = '0;
        endfunction

        // Called for every result transfer.
        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: weight_out %0h last_result %0b",
                       got.weight_out, got.last_result);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.weight_out !== want.weight_out)
            begin
                $error("weight_out expected %0h actual %0h", want.weight_out, got.weight_out);
                failures++;
            end
            if (got.break_after !== want.break_after)
            begin
                $error("break_after expected %0b actual %0b", want.break_after, got.break_after);
                failures++;
            end
            if (got.part_limit !== want.part_limit)
            begin
                $error("part_limit expected %0h actual %0h", want.part_limit, got.part_limit);
                failures++;
            end
            if (got.error !== want.error)
            begin
                $error("error expected %0b actual %0b", want.error, got.error);
                failures++;
            end
            if (got.last_result !== want.last_result)
            begin
                $error("last_result expected %0b actual %0b", want.last_result, got.last_result);
                failures++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    item_t            item = '0;
    logic             cfg_we = 1'b0;
    logic [PC_W-1:0]  cfg_wdata = '0;
    logic             result_valid;
    result_t          result;

    partition_scoreboard sb;

    linear_partition_min_max dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Every result is checked at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_result(result);
    end

    // Holds start until the block takes the item, then records the transfer.
    task automatic send_item(item_t it);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_item(it);
    endtask

    // Drops start for a short random gap with the given likelihood.
    task automatic maybe_idle(int idle_pct);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Sends a fixed list of weights as one sequence.
    task automatic send_weights(logic [WEIGHT_W-1:0] ws[$]);
        item_t it;
        foreach (ws[i])
        begin
            it.weight = ws[i];
            it.last_item = (i == ws.size() - 1);
            send_item(it);
        end
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight(weight_mix_t mix);
        case (mix)
            MIX_SMALL:   return $urandom_range(0, 15);
            MIX_EXTREME:
            begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return '1;
                    default: return $urandom;
                endcase
            end
            default:     return $urandom;
        endcase
    endfunction

    // Mostly sequences that can be split; some too short, some overfilling the store.
    function automatic int pick_length(int parts);
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        if (parts == 0 || parts > STORE_DEPTH)
            return $urandom_range(1, 6);
        if (roll < ((parts > 32) ? 40 : 5))
            return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 3);
        if (roll < 88)
        begin
            top = (parts + 10 > STORE_DEPTH) ? STORE_DEPTH : parts + 10;
            return $urandom_range(parts, top);
        end
        return $urandom_range(1, parts);
    endfunction

    task automatic send_random_sequence(int len, weight_mix_t mix, int idle_pct);
        item_t it;
        for (int i = 0; i < len; i++)
        begin
            maybe_idle(idle_pct);
            it.weight = pick_weight(mix);
            it.last_item = (i == len - 1);
            send_item(it);
        end
    endtask

    // Writes parts_count once all pending results are out and the block has settled.
    task automatic write_parts(logic [PC_W-1:0] value);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_parts(value);
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial
    begin
        int phase_parts[6];
        int phase_idle[6];
        int phase_budget[6];
        int sent;
        int len;
        logic [WEIGHT_W-1:0] ws[$];

        sb = new();
        phase_parts  = '{1, 2, 7, 64, 3, 0};
        phase_idle   = '{0, 83, 17, 0, 83, 17};
        phase_budget = '{36, 36, 40, 64, 30, 36};
        phase_parts[5] = $urandom_range(1, 16);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single largest weight, and a sequence of zero weights.
        write_parts(7'd1);
        ws = '{32'hFFFF_FFFF};
        send_weights(ws);
        ws = '{32'h0, 32'h0, 32'h0};
        send_weights(ws);

        // Three parts: even split, extra boundary on the left, and too few items.
        write_parts(7'd3);
        ws = '{32'd10, 32'd10, 32'd10};
        send_weights(ws);
        ws = '{32'd1, 32'd1, 32'd1, 32'd100};
        send_weights(ws);
        ws = '{32'h0, 32'hFFFF_FFFF};
        send_weights(ws);

        // Zero parts and the largest register value are both bad part counts.
        write_parts(7'd0);
        ws = '{32'd7};
        send_weights(ws);
        write_parts(7'd127);
        ws = '{32'd1, 32'd2};
        send_weights(ws);

        // Random phases with different part counts and sender gaps.
        for (int p = 0; p < 6; p++)
        begin
            write_parts(phase_parts[p][PC_W-1:0]);
            sent = 0;
            while (sent < phase_budget[p])
            begin
                len = pick_length(phase_parts[p]);
                send_random_sequence(len, weight_mix_t'($urandom_range(0, 2)), phase_idle[p]);
                sent += len;
            end
        end
        start <= 1'b0;

        // Drain, then give any stray result time to show up.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung block.
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
